// ===== src/psm_pkg.sv =====
// Shared types and constants for the Potts Metropolis site update block.
// Depends on nothing; every other file imports it.
package psm_pkg;

    localparam int COORD_FIELD_W = 6;
    localparam int SPIN_W        = 2;
    localparam int DRAW_W        = 16;
    localparam int CHANGE_W      = 4;
    localparam int THR_W         = 16;
    localparam int THR_COUNT     = 4;
    localparam int CFG_INDEX_W   = 2;
    localparam int NEIGHBOURS    = 4;
    localparam int SLOT_COUNT    = 5;
    localparam int CNT_W         = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_THR_ONE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_TWO   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_THREE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_FOUR  = 2'd3;

    localparam logic [THR_W-1:0] THR_ONE_RESET   = 16'd20218;
    localparam logic [THR_W-1:0] THR_TWO_RESET   = 16'd6231;
    localparam logic [THR_W-1:0] THR_THREE_RESET = 16'd1922;
    localparam logic [THR_W-1:0] THR_FOUR_RESET  = 16'd593;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CNT_W-1:0] SLOT_XP     = 3'd0;
    localparam logic [CNT_W-1:0] SLOT_XM     = 3'd1;
    localparam logic [CNT_W-1:0] SLOT_YP     = 3'd2;
    localparam logic [CNT_W-1:0] SLOT_YM     = 3'd3;
    localparam logic [CNT_W-1:0] SLOT_CENTER = 3'd4;
    localparam logic [CNT_W-1:0] READ_LAST   = 3'd5;

    localparam logic signed [CHANGE_W-1:0] CHANGE_ONE   = 4'sd1;
    localparam logic signed [CHANGE_W-1:0] CHANGE_TWO   = 4'sd2;
    localparam logic signed [CHANGE_W-1:0] CHANGE_THREE = 4'sd3;
    localparam logic signed [CHANGE_W-1:0] CHANGE_FOUR  = 4'sd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [THR_COUNT-1:0][THR_W-1:0] t_thresholds;

endpackage

// ===== src/psm_in_if.sv =====
// Input channel of the site update block: update or read items.
// Depends on psm_pkg for field widths.
interface psm_in_if import psm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [COORD_FIELD_W-1:0] site_x;
    logic [COORD_FIELD_W-1:0] site_y;
    logic [SPIN_W-1:0]        proposed_spin;
    logic [DRAW_W-1:0]        random_draw;

    modport source (output valid, operation, site_x, site_y, proposed_spin, random_draw,
                    input ready);
    modport sink (input valid, operation, site_x, site_y, proposed_spin, random_draw,
                  output ready);
endinterface

// ===== src/psm_out_if.sv =====
// Output channel of the site update block: one result per item.
// Depends on psm_pkg for field widths.
interface psm_out_if import psm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [SPIN_W-1:0]          site_spin;
    logic signed [CHANGE_W-1:0] match_change;

    modport source (output valid, accepted, site_spin, match_change, input ready);
    modport sink (input valid, accepted, site_spin, match_change, output ready);
endinterface

// ===== src/psm_front.sv =====
// Front end: takes input transfers, wraps coordinates onto the lattice, packs jobs.
// Depends on psm_pkg and psm_in_if.
module psm_front import psm_pkg::*; #(
    parameter int LATTICE_SIDE = 64,
    parameter int CW           = 6,
    parameter int JW           = 36
) (
    psm_in_if.sink           i_in,
    input  t_q_status        i_q_status,
    input  logic             i_lattice_ready,
    output logic             o_push,
    output logic [JW-1:0]    o_job
);

    function automatic logic [CW-1:0] wrap_coord(input logic [COORD_FIELD_W-1:0] v);
        logic [9:0] rem;
        rem = '0;
        for (int i = COORD_FIELD_W - 1; i >= 0; i--) begin
            rem = {rem[8:0], v[i]};
            if (rem >= 10'(LATTICE_SIDE)) begin
                rem = rem - 10'(LATTICE_SIDE);
            end
        end
        return rem[CW-1:0];
    endfunction

    assign i_in.ready = i_lattice_ready && !i_q_status.full;
    assign o_push     = i_in.valid && i_in.ready;
    assign o_job      = {i_in.operation, wrap_coord(i_in.site_x), wrap_coord(i_in.site_y),
                         i_in.proposed_spin, i_in.random_draw};

endmodule

// ===== src/psm_queue.sv =====
// Short job queue between the front end and the lattice engine.
// Depends on psm_pkg.
module psm_queue import psm_pkg::*; #(
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    logic [WIDTH-1:0]  r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== src/psm_back.sv =====
// Lattice engine: holds the spin memory, reads the site and four neighbours, decides
// acceptance, writes back, drives the result register. Uses psm_pkg and psm_out_if.
module psm_back import psm_pkg::*; #(
    parameter int LATTICE_SIDE = 64,
    parameter int SPIN_STATES  = 3,
    parameter int CW           = 6,
    parameter int JW           = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [JW-1:0] i_job,
    input  t_q_status     i_q_status,
    input  t_thresholds   i_thr,
    output logic          o_pop,
    output logic          o_lattice_ready,
    psm_out_if.source     o_out
);

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW         = $clog2(SITE_COUNT);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [AW-1:0]     r_clr_addr;
    logic [SPIN_W-1:0] r_slot [SLOT_COUNT];
    logic [SPIN_W-1:0] r_mem [SITE_COUNT];
    logic [SPIN_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic              r_out_accepted;
    logic [SPIN_W-1:0] r_out_spin;
    logic signed [CHANGE_W-1:0] r_out_change;

    logic              job_op;
    logic [CW-1:0]     job_x;
    logic [CW-1:0]     job_y;
    logic [SPIN_W-1:0] job_spin;
    logic [DRAW_W-1:0] job_draw;
    logic [CW-1:0]     x_plus;
    logic [CW-1:0]     x_minus;
    logic [CW-1:0]     y_plus;
    logic [CW-1:0]     y_minus;
    logic [CW-1:0]     rd_x;
    logic [CW-1:0]     rd_y;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     center_addr;
    logic [2:0]        old_matches;
    logic [2:0]        new_matches;
    logic signed [CHANGE_W-1:0] change;
    logic [THR_W-1:0]  thr_sel;
    logic              spin_legal;
    logic              pass;
    logic              accept_now;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SPIN_W-1:0] mem_wdata;
    logic              capture;
    logic              load_out;

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(x) * AW'(LATTICE_SIDE) + AW'(y);
    endfunction

    function automatic logic [2:0] count_matches(input logic [SPIN_W-1:0] value);
        logic [2:0] cnt;
        cnt = '0;
        for (int i = 0; i < NEIGHBOURS; i++) begin
            cnt = cnt + 3'(r_slot[i] == value);
        end
        return cnt;
    endfunction

    assign {job_op, job_x, job_y, job_spin, job_draw} = i_job;

    assign x_plus  = (job_x == CW'(LATTICE_SIDE - 1)) ? '0 : job_x + 1'b1;
    assign x_minus = (job_x == '0) ? CW'(LATTICE_SIDE - 1) : job_x - 1'b1;
    assign y_plus  = (job_y == CW'(LATTICE_SIDE - 1)) ? '0 : job_y + 1'b1;
    assign y_minus = (job_y == '0) ? CW'(LATTICE_SIDE - 1) : job_y - 1'b1;

    always_comb begin
        unique case (r_cnt)
            SLOT_XP: begin
                rd_x = x_plus;
                rd_y = job_y;
            end
            SLOT_XM: begin
                rd_x = x_minus;
                rd_y = job_y;
            end
            SLOT_YP: begin
                rd_x = job_x;
                rd_y = y_plus;
            end
            SLOT_YM: begin
                rd_x = job_x;
                rd_y = y_minus;
            end
            default: begin
                rd_x = job_x;
                rd_y = job_y;
            end
        endcase
    end

    assign rd_addr     = site_addr(rd_x, rd_y);
    assign center_addr = site_addr(job_x, job_y);

    always_comb begin
        old_matches = count_matches(r_slot[SLOT_CENTER]);
        new_matches = count_matches(job_spin);
    end

    assign change      = CHANGE_W'(signed'({1'b0, old_matches}) - signed'({1'b0, new_matches}));

    always_comb begin
        unique case (change)
            CHANGE_ONE:   thr_sel = i_thr[0];
            CHANGE_TWO:   thr_sel = i_thr[1];
            CHANGE_THREE: thr_sel = i_thr[2];
            CHANGE_FOUR:  thr_sel = i_thr[3];
            default:      thr_sel = '0;
        endcase
    end

    assign spin_legal = ({1'b0, job_spin} < (SPIN_W+1)'(SPIN_STATES));
    assign pass       = (change <= 0) || (thr_sel > job_draw);
    assign accept_now = (job_op == OP_UPDATE) && spin_legal && pass;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(SITE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_cnt == READ_LAST) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = center_addr;
        mem_wdata = job_spin;
        capture   = 1'b0;
        load_out  = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE: begin
            end
            S_READ: begin
                capture = (r_cnt != '0);
            end
            S_DECIDE: begin
                load_out = out_free;
                o_pop    = out_free;
                mem_we   = out_free && accept_now;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_slot[r_cnt - 1'b1] <= r_rd_data;
        end
        if (load_out) begin
            r_out_accepted <= accept_now;
            r_out_spin     <= accept_now ? job_spin : r_slot[SLOT_CENTER];
            r_out_change   <= (job_op == OP_READ) ? '0 : change;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_lattice_ready    = (r_state != S_CLEAR);
    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_out_accepted;
    assign o_out.site_spin    = r_out_spin;
    assign o_out.match_change = r_out_change;

endmodule

// ===== src/potts_metropolis_site_update.sv =====
// Top level of the Potts Metropolis site update block: threshold registers,
// front end, job queue and lattice engine. Depends on psm_pkg, psm_in_if,
// psm_out_if, psm_front, psm_queue and psm_back.
//
// Usage: items arrive on i_in (valid/ready); a transfer carries an update attempt
// (operation 0) or a spin read (operation 1). Each item yields one result on o_out.
// Coordinates wrap modulo LATTICE_SIDE. Thresholds are written through i_cfg_we,
// i_cfg_index and i_cfg_data while the block is idle. The user is bound to that;
// the block itself does not enforce it. The engine takes one item at a time:
// the single read port of the spin memory reads the site and its four neighbours
// one per cycle before the decision. Reset: thresholds return to their defaults
// and a clearing pass writes zero to every site; i_in.ready stays low until it
// ends. When the receiver stalls, the result holds in the output register; up to
// two further items wait in the job queue, then i_in.ready drops.
module potts_metropolis_site_update import psm_pkg::*; #(
    parameter int LATTICE_SIDE = 64,
    parameter int SPIN_STATES  = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    psm_in_if.sink                 i_in,
    psm_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]       i_cfg_data
);

    localparam int CW = $clog2(LATTICE_SIDE);
    localparam int JW = 1 + 2 * CW + SPIN_W + DRAW_W;

    t_thresholds   r_thr;
    t_q_status     q_status;
    logic          push;
    logic          pop;
    logic          lattice_ready;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= THR_ONE_RESET;
            r_thr[1] <= THR_TWO_RESET;
            r_thr[2] <= THR_THREE_RESET;
            r_thr[3] <= THR_FOUR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THR_ONE:   r_thr[0] <= i_cfg_data;
                CFG_THR_TWO:   r_thr[1] <= i_cfg_data;
                CFG_THR_THREE: r_thr[2] <= i_cfg_data;
                CFG_THR_FOUR:  r_thr[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psm_front #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .CW           (CW),
        .JW           (JW)
    ) u_front (
        .i_in            (i_in),
        .i_q_status      (q_status),
        .i_lattice_ready (lattice_ready),
        .o_push          (push),
        .o_job           (job_in)
    );

    psm_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .i_pop    (pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    psm_back #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .SPIN_STATES  (SPIN_STATES),
        .CW           (CW),
        .JW           (JW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job_out),
        .i_q_status      (q_status),
        .i_thr           (r_thr),
        .o_pop           (pop),
        .o_lattice_ready (lattice_ready),
        .o_out           (o_out)
    );

endmodule

// ===== test/psm_site_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Potts Metropolis site update block: keeps its own lattice and
// thresholds, predicts each result and compares it on the output channel.
// Depends on psm_pkg, psm_in_if and psm_out_if.
module psm_site_checker import psm_pkg::*; #(
    parameter int LATTICE_SIDE = 64,
    parameter int SPIN_STATES  = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    psm_in_if                      i_in_ch,
    psm_out_if                     i_out_ch,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]       i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic                       accepted;
        logic [SPIN_W-1:0]          site_spin;
        logic signed [CHANGE_W-1:0] match_change;
    } t_site_result;

    logic [SPIN_W-1:0] spin_grid [LATTICE_SIDE][LATTICE_SIDE];
    t_thresholds       thr;
    t_site_result      expected_results [$];
    int                mismatch_count = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int count_matches(int x, int y, logic [SPIN_W-1:0] value);
        int n;
        n = 0;
        n += int'(spin_grid[(x + 1) % LATTICE_SIDE][y] == value);
        n += int'(spin_grid[(x + LATTICE_SIDE - 1) % LATTICE_SIDE][y] == value);
        n += int'(spin_grid[x][(y + 1) % LATTICE_SIDE] == value);
        n += int'(spin_grid[x][(y + LATTICE_SIDE - 1) % LATTICE_SIDE] == value);
        return n;
    endfunction

    function automatic t_site_result predict_site_update(
        logic op, logic [COORD_FIELD_W-1:0] sx, logic [COORD_FIELD_W-1:0] sy,
        logic [SPIN_W-1:0] proposed, logic [DRAW_W-1:0] draw);
        t_site_result r;
        int x;
        int y;
        logic [SPIN_W-1:0] old_spin;
        logic signed [CHANGE_W-1:0] chg;
        logic take;
        x = int'(sx) % LATTICE_SIDE;
        y = int'(sy) % LATTICE_SIDE;
        r = '0;
        if (op == OP_UPDATE) begin
            old_spin = spin_grid[x][y];
            chg = CHANGE_W'(count_matches(x, y, old_spin) - count_matches(x, y, proposed));
            r.match_change = chg;
            case (chg)
                CHANGE_ONE:   take = thr[CFG_THR_ONE] > draw;
                CHANGE_TWO:   take = thr[CFG_THR_TWO] > draw;
                CHANGE_THREE: take = thr[CFG_THR_THREE] > draw;
                CHANGE_FOUR:  take = thr[CFG_THR_FOUR] > draw;
                default:      take = 1'b1;
            endcase
            if (int'(proposed) < SPIN_STATES && take) begin
                spin_grid[x][y] = proposed;
                r.accepted = 1'b1;
            end
        end
        r.site_spin = spin_grid[x][y];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_site_result got;
        t_site_result want;
        if (!i_rst_n) begin
            for (int x = 0; x < LATTICE_SIDE; x++) begin
                for (int y = 0; y < LATTICE_SIDE; y++) begin
                    spin_grid[x][y] = '0;
                end
            end
            thr[CFG_THR_ONE]   = THR_ONE_RESET;
            thr[CFG_THR_TWO]   = THR_TWO_RESET;
            thr[CFG_THR_THREE] = THR_THREE_RESET;
            thr[CFG_THR_FOUR]  = THR_FOUR_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                thr[i_cfg_index] = i_cfg_data;
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_results.push_back(predict_site_update(i_in_ch.operation,
                    i_in_ch.site_x, i_in_ch.site_y, i_in_ch.proposed_spin,
                    i_in_ch.random_draw));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.accepted     = i_out_ch.accepted;
                got.site_spin    = i_out_ch.site_spin;
                got.match_change = i_out_ch.match_change;
                if (expected_results.size() == 0) begin
                    report_mismatch("result count", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.site_spin !== want.site_spin)
                        report_mismatch("site_spin", got.site_spin, want.site_spin);
                    if (got.match_change !== want.match_change)
                        report_mismatch("match_change", $signed(got.match_change),
                                        $signed(want.match_change));
                end
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== test/potts_metropolis_site_update_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for potts_metropolis_site_update: drives update and read items
// and threshold writes; psm_site_checker predicts and compares the results.
// Depends on psm_pkg, psm_in_if, psm_out_if, the block and psm_site_checker.
module potts_metropolis_site_update_tb;
    import psm_pkg::*;

    localparam int SIDE        = 64;
    localparam int STATES      = 3;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 300;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THR_W-1:0]       cfg_data;
    t_thresholds            thr_shadow;
    int                     items_sent;
    int                     results_taken;
    int                     mismatches;
    int                     pending;

    psm_in_if  in_ch ();
    psm_out_if out_ch ();

    potts_metropolis_site_update #(
        .LATTICE_SIDE (SIDE),
        .SPIN_STATES  (STATES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    psm_site_checker #(
        .LATTICE_SIDE (SIDE),
        .SPIN_STATES  (STATES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, two bursts with none, and one long hold-off.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        results_taken = 0;
        @(posedge i_clk);
        forever begin
            if (results_taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((results_taken >= 150 && results_taken < 250) ||
                     (results_taken >= 850 && results_taken < 950))
                stall = 0;
            else
                stall = $urandom_range(0, 9);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            results_taken++;
        end
    end

    task automatic send_item(logic op, logic [COORD_FIELD_W-1:0] sx,
                             logic [COORD_FIELD_W-1:0] sy, logic [SPIN_W-1:0] spin,
                             logic [DRAW_W-1:0] draw);
        int gap;
        if ((items_sent >= 100 && items_sent < 180) || (items_sent >= 800 && items_sent < 900))
            gap = 0;
        else
            gap = $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.site_x        <= sx;
        in_ch.site_y        <= sy;
        in_ch.proposed_spin <= spin;
        in_ch.random_draw   <= draw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Most sites fall in a small window across the wrap so neighbours interact.
    task automatic send_random_items(int count);
        logic                     op;
        logic [COORD_FIELD_W-1:0] sx;
        logic [COORD_FIELD_W-1:0] sy;
        logic [DRAW_W-1:0]        draw;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_UPDATE;
            if ($urandom_range(0, 9) < 7) begin
                sx = COORD_FIELD_W'(60 + $urandom_range(0, 7));
                sy = COORD_FIELD_W'(60 + $urandom_range(0, 7));
            end else begin
                sx = COORD_FIELD_W'($urandom_range(0, 63));
                sy = COORD_FIELD_W'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 1) == 0)
                draw = DRAW_W'($urandom);
            else
                draw = thr_shadow[$urandom_range(0, 3)] + DRAW_W'($urandom_range(0, 4))
                       - DRAW_W'(2);
            send_item(op, sx, sy, SPIN_W'($urandom_range(0, 3)), draw);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_threshold(logic [CFG_INDEX_W-1:0] idx, logic [THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        thr_shadow[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic load_thresholds(logic [THR_W-1:0] t1, logic [THR_W-1:0] t2,
                                   logic [THR_W-1:0] t3, logic [THR_W-1:0] t4);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        write_threshold(CFG_THR_ONE, t1);
        write_threshold(CFG_THR_TWO, t2);
        write_threshold(CFG_THR_THREE, t3);
        write_threshold(CFG_THR_FOUR, t4);
        cfg_we <= 1'b0;
    endtask

    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.operation     <= OP_UPDATE;
        in_ch.site_x        <= '0;
        in_ch.site_y        <= '0;
        in_ch.proposed_spin <= '0;
        in_ch.random_draw   <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_THR_ONE;
        cfg_data            <= '0;
        i_rst_n             <= 1'b0;
        thr_shadow[CFG_THR_ONE]   = THR_ONE_RESET;
        thr_shadow[CFG_THR_TWO]   = THR_TWO_RESET;
        thr_shadow[CFG_THR_THREE] = THR_THREE_RESET;
        thr_shadow[CFG_THR_FOUR]  = THR_FOUR_RESET;
        items_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_READ,   6'd0,  6'd0,  2'd0, 16'hFFFF);
        send_item(OP_UPDATE, 6'd0,  6'd0,  2'd0, 16'hFFFF);
        send_item(OP_UPDATE, 6'd63, 6'd63, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd10, 6'd10, 2'd2, 16'hFFFF);
        send_item(OP_UPDATE, 6'd5,  6'd5,  2'd3, 16'h0000);
        send_item(OP_READ,   6'd63, 6'd63, 2'd3, 16'h0000);
        send_item(OP_UPDATE, 6'd0,  6'd63, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd63, 6'd0,  2'd2, 16'h0001);
        // surround one site with spin 1, then flip it both ways
        send_item(OP_UPDATE, 6'd21, 6'd20, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd19, 6'd20, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd20, 6'd21, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd20, 6'd19, 2'd1, 16'h0000);
        send_item(OP_UPDATE, 6'd20, 6'd20, 2'd1, 16'hFFFF);
        send_item(OP_UPDATE, 6'd20, 6'd20, 2'd2, 16'd592);
        send_item(OP_UPDATE, 6'd20, 6'd20, 2'd1, 16'd593);
        send_item(OP_UPDATE, 6'd20, 6'd20, 2'd0, 16'd593);
        send_item(OP_READ,   6'd20, 6'd20, 2'd0, 16'd0);
        send_item(OP_UPDATE, 6'd21, 6'd20, 2'd0, 16'd20217);
        send_item(OP_READ,   6'd63, 6'd0,  2'd1, 16'd0);
        in_ch.valid <= 1'b0;

        load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        send_random_items(200);
        load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random_items(200);
        load_thresholds(THR_W'($urandom), THR_W'($urandom), THR_W'($urandom),
                        THR_W'($urandom));
        send_random_items(300);
        load_thresholds(THR_ONE_RESET, THR_TWO_RESET, THR_THREE_RESET, THR_FOUR_RESET);
        send_random_items(400);

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/psm_pkg.sv
src/psm_in_if.sv
src/psm_out_if.sv
src/psm_front.sv
src/psm_queue.sv
src/psm_back.sv
src/potts_metropolis_site_update.sv
test/psm_site_checker.sv
test/potts_metropolis_site_update_tb.sv
